// File: hw/rtl/wcov_pkg.sv
`timescale 1ns / 1ps

package wcov_pkg;

	// sizes of the data set and of the item fields
	localparam int MAX_ROWS = 1024;
	localparam int MAX_DIMS = 4;
	localparam int NVAR     = 4;
	localparam int IDX_W    = 2;
	localparam int VAL_W    = 16;
	localparam int WGT_W    = 16;
	localparam int OUT_W    = 48;

	// derived widths of counters, sums and the long division
	localparam int ROW_W    = $clog2(MAX_ROWS + 1);
	localparam int LOG_ROWS = $clog2(MAX_ROWS);
	localparam int WT_W     = WGT_W + LOG_ROWS;
	localparam int PROD_W   = VAL_W + WGT_W + 1;
	localparam int PROD2_W  = PROD_W + VAL_W;
	localparam int SX_W     = PROD_W + LOG_ROWS + 1;
	localparam int SXY_W    = PROD2_W + LOG_ROWS + 1;
	localparam int DEN_W    = 2 * WT_W;
	localparam int NUM_W    = 2 * SX_W + 2;
	localparam int DCNT_W   = $clog2(NUM_W + 1);

	// cycles for the last row to reach every accumulator of the cell chain
	localparam int DRAIN_CYC = MAX_DIMS + 4;
	localparam int DRN_W     = $clog2(DRAIN_CYC + 1);

	// configuration
	localparam int PADDR_W = 3;
	localparam logic REG_DIMS = 1'b0;
	localparam logic [2:0] DIMS_RESET = 3'd4;

	// result codes
	localparam logic KIND_CENTER = 1'b0;
	localparam logic KIND_COV    = 1'b1;
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_ZERO_WT = 2'd1;
	localparam logic [1:0] STAT_DROPPED = 2'd2;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_SQ,
		ST_NEXT,
		ST_MULA,
		ST_MULB,
		ST_DIV,
		ST_OUT,
		ST_CLEAR
	} state_t;

	// one observation travelling along the cell chain
	typedef struct packed {
		logic                       valid;
		logic [WGT_W-1:0]           w;
		logic [NVAR-1:0][VAL_W-1:0] x;
	} row_t;

	// sums held by one cell
	typedef struct packed {
		logic [SX_W-1:0]            sx;
		logic [NVAR-1:0][SXY_W-1:0] sxy;
	} acc_t;

endpackage

// File: hw/rtl/wcov_if.sv
`timescale 1ns / 1ps

interface wcov_in_if;
	logic                 valid;
	logic                 ready;
	logic signed [15:0]   value_0;
	logic signed [15:0]   value_1;
	logic signed [15:0]   value_2;
	logic signed [15:0]   value_3;
	logic [15:0]          weight;
	logic                 final_row;

	modport source (output valid, value_0, value_1, value_2, value_3, weight, final_row,
		input ready);
	modport sink (input valid, value_0, value_1, value_2, value_3, weight, final_row,
		output ready);
endinterface

interface wcov_out_if;
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [1:0]           row_index;
	logic [1:0]           col_index;
	logic signed [47:0]   value;
	logic [1:0]           status;
	logic                 last_result;

	modport source (output valid, kind, row_index, col_index, value, status, last_result,
		input ready);
	modport sink (input valid, kind, row_index, col_index, value, status, last_result,
		output ready);
endinterface

// File: hw/rtl/weighted_covariance_core.sv
`timescale 1ns / 1ps

// Weighted mean and covariance of up to 1024 observation rows. While loading, one row
// is taken every cycle; each row streams through a chain of four cells, one per
// variable, that keep the running sums, so no row store is needed. After the row marked
// final_row the core waits for the chain to drain, squares the total weight, and then
// produces dims_in_use centers and dims_in_use squared covariance entries. A center is
// computed by the bit-serial divider; a covariance entry by the serial shift-add
// multiplier and then the divider. A total weight of zero skips the arithmetic. No
// rows are taken until the last result of a run has been delivered; the sums are then
// cleared.
module weighted_covariance_core (
	input  logic                          clk,
	input  logic                          arst_n,
	wcov_in_if.sink                       in_ch,
	wcov_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wcov_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam logic [wcov_pkg::NUM_W-1:0] SAT_POS =
		{{(wcov_pkg::NUM_W - wcov_pkg::OUT_W + 1){1'b0}}, {(wcov_pkg::OUT_W - 1){1'b1}}};
	localparam logic [wcov_pkg::NUM_W-1:0] SAT_NEG = SAT_POS + 1'b1;

	wcov_pkg::state_t                 state_q, state_d;
	logic [wcov_pkg::DRN_W-1:0]       drain_cnt_q;
	logic [wcov_pkg::ROW_W-1:0]       row_count_q;
	logic [wcov_pkg::WT_W-1:0]        wt_q;
	logic                             ovf_q;
	logic [2:0]                       dims_q;
	logic                             kind_q;
	logic [wcov_pkg::IDX_W-1:0]       ri_q, cj_q;

	logic signed [wcov_pkg::NUM_W-1:0] a_q, acc_q;
	logic [wcov_pkg::SX_W-1:0]        b_q, mag_q;
	logic [wcov_pkg::DEN_W-1:0]       wsq_q;
	logic                             neg_q;
	logic [wcov_pkg::OUT_W-1:0]       val_q;

	logic                             in_ready_c, out_valid_c, acc_clear_c;
	logic                             in_acc, out_acc, full, last_c, wt_zero;
	logic [2:0]                       deff, dm1;
	logic [wcov_pkg::IDX_W-1:0]       dlast, rd_idx;
	logic [wcov_pkg::SX_W-1:0]        sx_sel;
	logic [wcov_pkg::SXY_W-1:0]       sxy_sel;
	logic signed [wcov_pkg::NUM_W-1:0] sx_ext, div_num;
	logic [wcov_pkg::DEN_W-1:0]       div_den;
	logic                             div_start, div_done, div_neg;
	logic [wcov_pkg::NUM_W-1:0]       div_quo;
	logic [wcov_pkg::OUT_W-1:0]       sat_c;
	logic [1:0]                       status_c;

	wcov_pkg::row_t                   row_c [wcov_pkg::MAX_DIMS];
	wcov_pkg::acc_t                   cell_acc [wcov_pkg::MAX_DIMS];

	// handshakes and effective dimension count
	assign in_acc  = in_ch.valid && in_ready_c;
	assign out_acc = out_valid_c && out_ch.ready;
	assign full    = (row_count_q == wcov_pkg::ROW_W'(wcov_pkg::MAX_ROWS));
	assign wt_zero = (wt_q == '0);
	assign deff    = (dims_q == 3'd0) ? 3'd1 :
		((dims_q > 3'(wcov_pkg::MAX_DIMS)) ? 3'(wcov_pkg::MAX_DIMS) : dims_q);
	assign dm1     = deff - 3'd1;
	assign dlast   = dm1[wcov_pkg::IDX_W-1:0];
	assign last_c  = (kind_q == wcov_pkg::KIND_COV) && (ri_q == dlast) && (cj_q == dlast);

	// feed an accepted row into the chain unless the data set is full
	assign row_c[0].valid = in_acc && !full;
	assign row_c[0].w     = in_ch.weight;
	assign row_c[0].x     = {in_ch.value_3, in_ch.value_2, in_ch.value_1, in_ch.value_0};

	for (genvar k = 0; k < wcov_pkg::MAX_DIMS; k++) begin : g_cell
		if (k == wcov_pkg::MAX_DIMS - 1) begin : g_tail
			wcov_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clear    (acc_clear_c),
				.cell_idx (wcov_pkg::IDX_W'(k)),
				.row_i    (row_c[k]),
				.row_o    (),
				.acc_o    (cell_acc[k])
			);
		end else begin : g_link
			wcov_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clear    (acc_clear_c),
				.cell_idx (wcov_pkg::IDX_W'(k)),
				.row_i    (row_c[k]),
				.row_o    (row_c[k+1]),
				.acc_o    (cell_acc[k])
			);
		end
	end

	// read the sums of the current entry
	assign rd_idx  = (state_q == wcov_pkg::ST_MULA) ? cj_q : ri_q;
	assign sx_sel  = cell_acc[rd_idx].sx;
	assign sxy_sel = cell_acc[ri_q].sxy[cj_q];
	assign sx_ext  = {{(wcov_pkg::NUM_W - wcov_pkg::SX_W){sx_sel[wcov_pkg::SX_W-1]}}, sx_sel};

	// divider operands: center from the weighted sum, covariance from the accumulator
	assign div_start = (state_q == wcov_pkg::ST_NEXT && !wt_zero && kind_q == wcov_pkg::KIND_CENTER)
		|| (state_q == wcov_pkg::ST_MULB && b_q == '0);
	assign div_num = (kind_q == wcov_pkg::KIND_CENTER) ? (sx_ext <<< 8) : acc_q;
	assign div_den = (kind_q == wcov_pkg::KIND_CENTER) ? wcov_pkg::DEN_W'(wt_q) : wsq_q;

	wcov_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.neg    (div_neg),
		.quo    (div_quo)
	);

	// saturate the quotient to the result width
	always_comb begin
		if (div_neg) begin
			if (div_quo > SAT_NEG) begin
				sat_c = {1'b1, {(wcov_pkg::OUT_W - 1){1'b0}}};
			end else begin
				sat_c = ~div_quo[wcov_pkg::OUT_W-1:0] + 1'b1;
			end
		end else if (div_quo > SAT_POS) begin
			sat_c = {1'b0, {(wcov_pkg::OUT_W - 1){1'b1}}};
		end else begin
			sat_c = div_quo[wcov_pkg::OUT_W-1:0];
		end
	end

	assign status_c = wt_zero ? wcov_pkg::STAT_ZERO_WT :
		(ovf_q ? wcov_pkg::STAT_DROPPED : wcov_pkg::STAT_OK);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wcov_pkg::ST_LOAD: begin
				if (in_acc && in_ch.final_row) state_d = wcov_pkg::ST_DRAIN;
			end
			wcov_pkg::ST_DRAIN: begin
				if (drain_cnt_q == wcov_pkg::DRN_W'(wcov_pkg::DRAIN_CYC - 1)) begin
					state_d = wcov_pkg::ST_SQ;
				end
			end
			wcov_pkg::ST_SQ: begin
				if (b_q == '0) state_d = wcov_pkg::ST_NEXT;
			end
			wcov_pkg::ST_NEXT: begin
				if (wt_zero) state_d = wcov_pkg::ST_OUT;
				else if (kind_q == wcov_pkg::KIND_CENTER) state_d = wcov_pkg::ST_DIV;
				else state_d = wcov_pkg::ST_MULA;
			end
			wcov_pkg::ST_MULA: begin
				if (b_q == '0) state_d = wcov_pkg::ST_MULB;
			end
			wcov_pkg::ST_MULB: begin
				if (b_q == '0) state_d = wcov_pkg::ST_DIV;
			end
			wcov_pkg::ST_DIV: begin
				if (div_done) state_d = wcov_pkg::ST_OUT;
			end
			wcov_pkg::ST_OUT: begin
				if (out_acc) state_d = last_c ? wcov_pkg::ST_CLEAR : wcov_pkg::ST_NEXT;
			end
			wcov_pkg::ST_CLEAR: begin
				state_d = wcov_pkg::ST_LOAD;
			end
			default: begin
				state_d = wcov_pkg::ST_LOAD;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready_c  = 1'b0;
		out_valid_c = 1'b0;
		acc_clear_c = 1'b0;
		case (state_q)
			wcov_pkg::ST_LOAD:  in_ready_c  = 1'b1;
			wcov_pkg::ST_OUT:   out_valid_c = 1'b1;
			wcov_pkg::ST_CLEAR: acc_clear_c = 1'b1;
			default: begin
				in_ready_c = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wcov_pkg::ST_LOAD;
			drain_cnt_q <= '0;
			row_count_q <= '0;
			wt_q        <= '0;
			ovf_q       <= 1'b0;
			dims_q      <= wcov_pkg::DIMS_RESET;
			kind_q      <= wcov_pkg::KIND_CENTER;
			ri_q        <= '0;
			cj_q        <= '0;
		end else begin
			state_q <= state_d;

			if (psel && penable && pwrite && paddr[2] == wcov_pkg::REG_DIMS) begin
				dims_q <= pwdata[2:0];
			end

			// count rows and weight, flag rows past capacity
			if (in_acc) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					row_count_q <= row_count_q + 1'b1;
					wt_q        <= wt_q + wcov_pkg::WT_W'(in_ch.weight);
				end
			end

			if (state_q == wcov_pkg::ST_DRAIN) drain_cnt_q <= drain_cnt_q + 1'b1;
			else drain_cnt_q <= '0;

			// advance to the next entry
			if (out_acc && !last_c) begin
				if (kind_q == wcov_pkg::KIND_CENTER) begin
					if (ri_q == dlast) begin
						kind_q <= wcov_pkg::KIND_COV;
						ri_q   <= '0;
						cj_q   <= '0;
					end else begin
						ri_q <= ri_q + 1'b1;
					end
				end else if (cj_q == dlast) begin
					cj_q <= '0;
					ri_q <= ri_q + 1'b1;
				end else begin
					cj_q <= cj_q + 1'b1;
				end
			end

			// drop the run after the last result
			if (state_q == wcov_pkg::ST_CLEAR) begin
				row_count_q <= '0;
				wt_q        <= '0;
				ovf_q       <= 1'b0;
				kind_q      <= wcov_pkg::KIND_CENTER;
				ri_q        <= '0;
				cj_q        <= '0;
			end
		end
	end

	// serial multiply datapath and result register
	always_ff @(posedge clk) begin
		case (state_q)
			wcov_pkg::ST_DRAIN: begin
				a_q   <= wcov_pkg::NUM_W'(wt_q);
				b_q   <= wcov_pkg::SX_W'(wt_q);
				acc_q <= '0;
			end
			wcov_pkg::ST_SQ: begin
				if (b_q == '0) begin
					wsq_q <= acc_q[wcov_pkg::DEN_W-1:0];
				end else begin
					if (b_q[0]) acc_q <= acc_q + a_q;
					a_q <= a_q <<< 1;
					b_q <= b_q >> 1;
				end
			end
			wcov_pkg::ST_NEXT: begin
				val_q <= '0;
				a_q   <= {{(wcov_pkg::NUM_W - wcov_pkg::SXY_W){sxy_sel[wcov_pkg::SXY_W-1]}},
					sxy_sel};
				b_q   <= wcov_pkg::SX_W'(wt_q);
				acc_q <= '0;
				neg_q <= sx_sel[wcov_pkg::SX_W-1];
				mag_q <= sx_sel[wcov_pkg::SX_W-1] ? (~sx_sel + 1'b1) : sx_sel;
			end
			wcov_pkg::ST_MULA: begin
				if (b_q == '0) begin
					a_q <= sx_ext;
					b_q <= mag_q;
				end else begin
					if (b_q[0]) acc_q <= acc_q + a_q;
					a_q <= a_q <<< 1;
					b_q <= b_q >> 1;
				end
			end
			wcov_pkg::ST_MULB: begin
				if (b_q != '0) begin
					if (b_q[0]) acc_q <= neg_q ? (acc_q + a_q) : (acc_q - a_q);
					a_q <= a_q <<< 1;
					b_q <= b_q >> 1;
				end
			end
			wcov_pkg::ST_DIV: begin
				if (div_done) val_q <= sat_c;
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	// ports
	assign in_ch.ready        = in_ready_c;
	assign out_ch.valid       = out_valid_c;
	assign out_ch.kind        = kind_q;
	assign out_ch.row_index   = ri_q;
	assign out_ch.col_index   = cj_q;
	assign out_ch.value       = val_q;
	assign out_ch.status      = status_c;
	assign out_ch.last_result = last_c;
	assign prdata             = 32'(dims_q);
	assign pready             = 1'b1;

	// loading and delivering never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("rows taken while a result is offered");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == wcov_pkg::ST_DIV)
		else $error("divider finished outside the divide step");

	// the last result of a run is followed by the clear
	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last_result) |=> state_q == wcov_pkg::ST_CLEAR)
		else $error("run did not clear after its last result");

	// the clear empties row count and weight
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wcov_pkg::ST_CLEAR |=> row_count_q == '0 && wt_q == '0)
		else $error("counts not cleared");

endmodule

// File: hw/rtl/wcov_cell.sv
`timescale 1ns / 1ps

module wcov_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic [wcov_pkg::IDX_W-1:0]  cell_idx,
	input  wcov_pkg::row_t              row_i,
	output wcov_pkg::row_t              row_o,
	output wcov_pkg::acc_t              acc_o
);

	logic signed [wcov_pkg::VAL_W-1:0]   xk;
	logic signed [wcov_pkg::PROD_W-1:0]  wx_c;
	logic signed [wcov_pkg::PROD2_W-1:0] prod_c [wcov_pkg::NVAR];

	logic                                            v_s1, v_s2;
	logic signed [wcov_pkg::PROD_W-1:0]              wx_s1, wx_s2;
	logic [wcov_pkg::NVAR-1:0][wcov_pkg::VAL_W-1:0]  xs_s1;
	logic [wcov_pkg::NVAR-1:0][wcov_pkg::PROD2_W-1:0] prod_s2;
	wcov_pkg::acc_t                                  acc_q;

	// weight times this cell's variable
	assign xk   = $signed(row_i.x[cell_idx]);
	assign wx_c = $signed({1'b0, row_i.w}) * xk;

	// weighted variable times every variable of the row
	always_comb begin
		for (int j = 0; j < wcov_pkg::NVAR; j++) begin
			prod_c[j] = wx_s1 * $signed(xs_s1[j]);
		end
	end

	// hand the row to the neighbor and track valid through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_o <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			row_o <= row_i;
			v_s1  <= row_i.valid;
			v_s2  <= v_s1;
		end
	end

	// product stages
	always_ff @(posedge clk) begin
		wx_s1 <= wx_c;
		xs_s1 <= row_i.x;
		wx_s2 <= wx_s1;
		for (int j = 0; j < wcov_pkg::NVAR; j++) begin
			prod_s2[j] <= prod_c[j];
		end
	end

	// accumulate the sums, drop them after a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q.sx <= acc_q.sx + {{(wcov_pkg::SX_W - wcov_pkg::PROD_W){wx_s2[wcov_pkg::PROD_W-1]}},
				wx_s2};
			for (int j = 0; j < wcov_pkg::NVAR; j++) begin
				acc_q.sxy[j] <= acc_q.sxy[j] +
					{{(wcov_pkg::SXY_W - wcov_pkg::PROD2_W){prod_s2[j][wcov_pkg::PROD2_W-1]}},
					prod_s2[j]};
			end
		end
	end

	assign acc_o = acc_q;

endmodule

// File: hw/rtl/wcov_div.sv
`timescale 1ns / 1ps

module wcov_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [wcov_pkg::NUM_W-1:0] num,
	input  logic [wcov_pkg::DEN_W-1:0]        den,
	output logic                              done,
	output logic                              neg,
	output logic [wcov_pkg::NUM_W-1:0]        quo
);

	logic                              busy_q, done_q;
	logic [wcov_pkg::DCNT_W-1:0]       cnt_q;
	logic [wcov_pkg::DEN_W-1:0]        rem_q, den_q;
	logic [wcov_pkg::NUM_W-1:0]        quo_q;
	logic                              neg_q;
	logic [wcov_pkg::DEN_W:0]          rem_sh;
	logic [wcov_pkg::DEN_W+1:0]        diff;

	// one quotient bit per cycle, restoring
	assign rem_sh = {rem_q, quo_q[wcov_pkg::NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= wcov_pkg::DCNT_W'(wcov_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == wcov_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[wcov_pkg::NUM_W-1];
			quo_q <= num[wcov_pkg::NUM_W-1] ? (~num + 1'b1) : num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[wcov_pkg::DEN_W+1]) begin
				rem_q <= diff[wcov_pkg::DEN_W-1:0];
				quo_q <= {quo_q[wcov_pkg::NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[wcov_pkg::DEN_W-1:0];
				quo_q <= {quo_q[wcov_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign neg  = neg_q;
	assign quo  = quo_q;

endmodule

// File: verif/wcov_moment_checker.sv
`timescale 1ns / 1ps

module wcov_moment_checker
	import wcov_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	wcov_in_if                   obs,
	wcov_out_if                  res,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output int                   pending,
	output int                   errors
);

	typedef struct packed {
		logic        kind;
		logic [1:0]  row_index;
		logic [1:0]  col_index;
		logic [47:0] value;
		logic [1:0]  status;
		logic        last_result;
	} moment_t;

	localparam logic signed [129:0] SAT_HI = (130'sd1 <<< 47) - 1;
	localparam logic signed [129:0] SAT_LO = -(130'sd1 <<< 47);

	moment_t expected_moments[$];

	// running sums of the data set being loaded
	longint      sum_x[NVAR];
	longint      sum_xy[NVAR][NVAR];
	longint      weight_sum;
	int          rows_held;
	bit          rows_dropped;
	logic [2:0]  dims_reg;

	assign pending = expected_moments.size();

	// push centers, then covariance entries in row-major order, and clear the sums
	function automatic void predict_moments();
		int d, n, total;
		logic [1:0] stat;
		longint c;
		logic signed [129:0] num, den2, q, a, b;
		moment_t m;
		d = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS ? MAX_DIMS : int'(dims_reg));
		stat = (weight_sum == 0) ? STAT_ZERO_WT : (rows_dropped ? STAT_DROPPED : STAT_OK);
		total = d + d * d;
		n = 0;
		for (int i = 0; i < d; i++) begin
			c = (weight_sum != 0) ? (sum_x[i] * 256) / weight_sum : 0;
			n++;
			m = '{KIND_CENTER, 2'(i), 2'd0, c[47:0], stat, n == total};
			expected_moments.push_back(m);
		end
		for (int i = 0; i < d; i++)
			for (int j = 0; j < d; j++) begin
				q = 0;
				if (weight_sum != 0) begin
					a = 130'(weight_sum);
					b = 130'(sum_xy[i][j]);
					num = a * b;
					a = 130'(sum_x[i]);
					b = 130'(sum_x[j]);
					num = num - a * b;
					a = 130'(weight_sum);
					den2 = a * a;
					q = num / den2;
					if (q > SAT_HI) q = SAT_HI;
					if (q < SAT_LO) q = SAT_LO;
				end
				n++;
				m = '{KIND_COV, 2'(i), 2'(j), q[47:0], stat, n == total};
				expected_moments.push_back(m);
			end
		for (int i = 0; i < NVAR; i++) begin
			sum_x[i] = 0;
			for (int j = 0; j < NVAR; j++) sum_xy[i][j] = 0;
		end
		weight_sum = 0;
		rows_held = 0;
		rows_dropped = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint xv[NVAR];
		longint wv;
		moment_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < NVAR; i++) begin
				sum_x[i] = 0;
				for (int j = 0; j < NVAR; j++) sum_xy[i][j] = 0;
			end
			weight_sum = 0;
			rows_held = 0;
			rows_dropped = 0;
			dims_reg = DIMS_RESET;
			errors = 0;
			expected_moments.delete();
		end else begin
			// track the dims register
			if (psel && penable && pwrite && pready && paddr == PADDR_W'(REG_DIMS) << 2)
				dims_reg = pwdata[2:0];
			// accumulate an accepted observation, dropping rows past capacity
			if (obs.valid && obs.ready) begin
				if (rows_held < MAX_ROWS) begin
					xv[0] = longint'(obs.value_0);
					xv[1] = longint'(obs.value_1);
					xv[2] = longint'(obs.value_2);
					xv[3] = longint'(obs.value_3);
					wv = longint'(obs.weight);
					for (int i = 0; i < NVAR; i++) begin
						sum_x[i] += wv * xv[i];
						for (int j = 0; j < NVAR; j++) sum_xy[i][j] += wv * xv[i] * xv[j];
					end
					weight_sum += wv;
					rows_held++;
				end else begin
					rows_dropped = 1;
				end
				if (obs.final_row) predict_moments();
			end
			// compare an accepted result with the oldest expectation
			if (res.valid && res.ready) begin
				got = '{res.kind, res.row_index, res.col_index, res.value, res.status,
					res.last_result};
				if (expected_moments.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %h", got);
				end else begin
					want = expected_moments.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: exp kind %0d r%0d c%0d val %0d st %0d last %0d",
								want.kind, want.row_index, want.col_index,
								$signed(want.value), want.status, want.last_result);
							$display("          got kind %0d r%0d c%0d val %0d st %0d last %0d",
								got.kind, got.row_index, got.col_index,
								$signed(got.value), got.status, got.last_result);
						end
					end
				end
			end
		end
	end

endmodule

// File: verif/weighted_covariance_core_tb.sv
`timescale 1ns / 1ps

module weighted_covariance_core_tb;
	import wcov_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	int pending, errors;
	int cycles;
	int burst_left;
	int stall_cnt;

	wcov_in_if  obs_ch();
	wcov_out_if res_ch();

	weighted_covariance_core DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(obs_ch), .out_ch(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	wcov_moment_checker checker_i (
		.clk(clk), .arst_n(arst_n), .obs(obs_ch), .res(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .pending(pending), .errors(errors)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// stall the result channel: free flow, random, short holes, long stalls
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		case (stall_cnt[10:9])
			2'd0: res_ch.ready <= 1'b1;
			2'd1: res_ch.ready <= 1'($urandom_range(0, 1));
			2'd2: res_ch.ready <= (stall_cnt[3:0] != 0);
			default: res_ch.ready <= stall_cnt[5];
		endcase
	end

	// send one observation, opening a random gap between bursts
	task automatic push_observation(input logic [15:0] v0, v1, v2, v3, w,
		input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				obs_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		obs_ch.valid <= 1'b1;
		obs_ch.value_0 <= v0;
		obs_ch.value_1 <= v1;
		obs_ch.value_2 <= v2;
		obs_ch.value_3 <= v3;
		obs_ch.weight <= w;
		obs_ch.final_row <= fin;
		@(posedge clk);
		while (!obs_ch.ready) @(posedge clk);
		burst_left--;
	endtask

	// hold off until every result is out and the core has cleared
	task automatic drain_results();
		obs_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_dims(input logic [2:0] dims);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(REG_DIMS) << 2;
		pwdata <= 32'(dims);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// data set of random rows; weight style picks small, full, mostly zero, or moderate weights
	task automatic push_random_set(input int rows);
		int style;
		logic [15:0] w;
		style = $urandom_range(0, 3);
		for (int r = 0; r < rows; r++) begin
			case (style)
				0: w = 16'($urandom_range(0, 3));
				1: w = 16'($urandom);
				2: w = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
				default: w = 16'($urandom_range(0, 300));
			endcase
			push_observation(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				w, r == rows - 1);
		end
	endtask

	initial begin
		logic [2:0] dims_plan[8];
		int sent;
		dims_plan = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd5, 3'd4, 3'd2};
		arst_n = 1'b0;
		cycles = 0;
		burst_left = 0;
		stall_cnt = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		obs_ch.valid = 1'b0;
		obs_ch.value_0 = '0;
		obs_ch.value_1 = '0;
		obs_ch.value_2 = '0;
		obs_ch.value_3 = '0;
		obs_ch.weight = '0;
		obs_ch.final_row = 1'b0;
		res_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes at full dims
		push_observation(16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'hffff, 1'b0);
		push_observation(16'h8000, 16'h7fff, 16'h0001, 16'h0100, 16'h0001, 1'b0);
		push_observation(16'h1234, 16'hedcb, 16'h8000, 16'h7fff, 16'h0000, 1'b0);
		push_observation(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 1'b1);
		// directed: one row alone, then zero total weight
		push_observation(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0001, 1'b1);
		push_observation(16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0, 16'h0000, 1'b0);
		push_observation(16'haaaa, 16'h5555, 16'hf0f0, 16'h0f0f, 16'h0000, 1'b1);
		push_observation(16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
		push_observation(16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff, 1'b1);

		// random sets under each dims setting, extremes and out-of-range values too
		sent = 9;
		for (int p = 0; p < 8; p++) begin
			write_dims(dims_plan[p]);
			for (int s = 0; s < 3; s++) begin
				int rows;
				rows = $urandom_range(1, 8);
				push_random_set(rows);
				sent += rows;
				// let the results drain once with the sender held
				if (p == 2 && s == 1) drain_results();
			end
		end
		while (sent < 120) begin
			push_random_set(4);
			sent += 4;
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
